// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the back stage
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FSAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define FSAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FSAT_ASSERT(lbl, prop, msg)
`define FSAT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/fsat_pkg.sv =====
// types, constants and helpers of the flow statistics table
package fsat_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int BYTES_W     = 40;
    localparam int DIVD_W      = BYTES_W + 3;
    localparam int DUR_W       = 32;
    localparam int BITS_W      = BYTES_W + 4;
    localparam int SUM_W       = 64;
    localparam int STEP_W      = $clog2(DIVD_W);
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic CFG_FILTER_EN = 1'b0;
    localparam logic CFG_FILTER_ID = 1'b1;

    localparam logic [1:0] CLS_APP = 2'd0;
    localparam logic [1:0] CLS_SRC = 2'd1;
    localparam logic [1:0] CLS_DST = 2'd2;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_CREATED  = 3'd1,
        ST_FILTERED = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADCLASS = 3'd4
    } t_status;

    // status ST_CREATED in a queued item means lookup still pending
    typedef struct packed {
        t_status              status;
        logic [1:0]           cls;
        logic [31:0]          key;
        logic [BYTES_W-1:0]   up_octets;
        logic [BYTES_W-1:0]   dn_octets;
        logic [DUR_W-1:0]     dur;
        logic [BITS_W-1:0]    bits;
    } t_item;

    typedef struct packed {
        logic [1:0]        cls;
        logic [31:0]       key;
        logic [31:0]       conns;
        logic [SUM_W-1:0]  up;
        logic [SUM_W-1:0]  dn;
        logic [SUM_W-1:0]  tot;
    } t_slot;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction
endpackage

// ===== hw/rtl/fsat_front.sv =====
// front stage: filter, class check, key select and bit total
module fsat_front import fsat_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_push,
    output logic               o_full,
    input  logic [31:0]        i_app_id,
    input  logic [31:0]        i_src_ip,
    input  logic [31:0]        i_dst_ip,
    input  logic [BYTES_W-1:0] i_up_octets,
    input  logic [BYTES_W-1:0] i_dn_octets,
    input  logic [DUR_W-1:0]   i_duration,
    input  logic [1:0]         i_agg_class,
    output logic               o_q_push,
    output t_item              o_q_item,
    input  t_q_stat            i_q_stat
);
    logic        r_filt_en;
    logic [31:0] r_filt_id;
    logic        r_vld;
    t_item       r_item;
    t_item       n_item;
    logic        acc;
    logic [BYTES_W:0] byte_sum;

    assign o_full   = r_vld && i_q_stat.full;
    assign o_q_push = r_vld && !i_q_stat.full;
    assign o_q_item = r_item;
    assign acc      = i_push && !o_full;
    assign byte_sum = {1'b0, i_up_octets} + {1'b0, i_dn_octets};

    always_comb begin
        n_item.cls        = i_agg_class;
        n_item.up_octets  = i_up_octets;
        n_item.dn_octets  = i_dn_octets;
        n_item.dur        = i_duration;
        n_item.bits       = {byte_sum, 3'b000};
        n_item.key        = i_app_id;
        n_item.status     = ST_CREATED;
        unique case (i_agg_class)
            CLS_APP: n_item.key = i_app_id;
            CLS_SRC: n_item.key = i_src_ip;
            CLS_DST: n_item.key = i_dst_ip;
            default: n_item.status = ST_BADCLASS;
        endcase
        // filter wins over a bad class
        if (r_filt_en && i_app_id != r_filt_id) begin
            n_item.status = ST_FILTERED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_en <= 1'b0;
            r_filt_id <= '0;
            r_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_FILTER_EN: r_filt_en <= i_cfg_wdata[0];
                    CFG_FILTER_ID: r_filt_id <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (acc) begin
                r_vld <= 1'b1;
            end else if (o_q_push) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_item <= n_item;
        end
    end
endmodule

// ===== hw/rtl/fsat_queue.sv =====
// short queue of classified records between front and back
module fsat_queue import fsat_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);
    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wp;
    logic [Q_PTR_W-1:0]  r_rp;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

// ===== hw/rtl/fsat_back.sv =====
// back stage: rate division, table search, update and result register
`include "assert_macros.svh"
module fsat_back import fsat_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_q_item,
    input  t_q_stat          i_q_stat,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [2:0]       o_status,
    output logic [IDX_W-1:0] o_entry_index,
    output logic [31:0]      o_conn_count,
    output logic [SUM_W-1:0] o_up_rate_sum,
    output logic [SUM_W-1:0] o_down_rate_sum,
    output logic [SUM_W-1:0] o_total_bits_sum,
    output logic [CNT_W-1:0] o_entries_used
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_CMP, S_EMIT} t_state;

    t_state              r_state;
    t_item               r_item;
    logic [DIVD_W-1:0]   r_up_q;
    logic [DIVD_W-1:0]   r_dn_q;
    logic [DUR_W-1:0]    r_up_rem;
    logic [DUR_W-1:0]    r_dn_rem;
    logic [STEP_W-1:0]   r_step;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_fill;
    t_slot               r_mem [TABLE_DEPTH];
    t_slot               r_rd;
    t_status             r_res_status;
    t_slot               r_res;
    logic [IDX_W-1:0]    r_res_idx;
    logic                r_out_vld;
    t_status             r_out_status;
    t_slot               r_out;
    logic [IDX_W-1:0]    r_out_idx;
    logic [CNT_W-1:0]    r_out_used;

    logic [DUR_W:0]      up_t;
    logic [DUR_W:0]      dn_t;
    logic                up_ge;
    logic                dn_ge;
    logic                hit;
    logic                at_end;
    logic                tbl_full;
    logic                out_load;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_wa;
    t_slot               new_slot;
    t_slot               upd_slot;
    t_slot               mem_wd;

    // one restoring step per cycle on both rates
    assign up_t  = {r_up_rem, r_up_q[DIVD_W-1]};
    assign dn_t  = {r_dn_rem, r_dn_q[DIVD_W-1]};
    assign up_ge = up_t >= {1'b0, r_item.dur};
    assign dn_ge = dn_t >= {1'b0, r_item.dur};

    assign hit      = (r_rd.cls == r_item.cls) && (r_rd.key == r_item.key);
    assign at_end   = (r_idx == r_fill);
    assign tbl_full = (r_fill == CNT_W'(TABLE_DEPTH));
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_stat.empty;
    assign out_load = (r_state == S_EMIT) && (!r_out_vld || i_pop);

    always_comb begin
        new_slot.cls   = r_item.cls;
        new_slot.key   = r_item.key;
        new_slot.conns = 32'd1;
        new_slot.up    = SUM_W'(r_up_q);
        new_slot.dn    = SUM_W'(r_dn_q);
        new_slot.tot   = SUM_W'(r_item.bits);
        upd_slot.cls   = r_rd.cls;
        upd_slot.key   = r_rd.key;
        upd_slot.conns = (r_rd.conns == '1) ? r_rd.conns : r_rd.conns + 32'd1;
        upd_slot.up    = sat_add(r_rd.up, SUM_W'(r_up_q));
        upd_slot.dn    = sat_add(r_rd.dn, SUM_W'(r_dn_q));
        upd_slot.tot   = sat_add(r_rd.tot, SUM_W'(r_item.bits));
        mem_we = 1'b0;
        mem_wa = r_idx[IDX_W-1:0];
        mem_wd = upd_slot;
        if (r_state == S_RD && at_end && !tbl_full) begin
            mem_we = 1'b1;
            mem_wa = r_fill[IDX_W-1:0];
            mem_wd = new_slot;
        end else if (r_state == S_CMP && hit) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (r_state == S_RD && !at_end) begin
            r_rd <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_item       <= i_q_item;
                        r_res_status <= i_q_item.status;
                        r_res        <= '0;
                        r_res_idx    <= '0;
                        r_up_q       <= '0;
                        r_dn_q       <= '0;
                        r_up_rem     <= '0;
                        r_dn_rem     <= '0;
                        r_step       <= '0;
                        r_idx        <= '0;
                        if (i_q_item.status != ST_CREATED) begin
                            r_state <= S_EMIT;
                        end else if (i_q_item.dur == '0) begin
                            r_state <= S_RD;
                        end else begin
                            r_up_q  <= {i_q_item.up_octets, 3'b000};
                            r_dn_q  <= {i_q_item.dn_octets, 3'b000};
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_up_rem <= up_ge ? DUR_W'(up_t - {1'b0, r_item.dur}) : up_t[DUR_W-1:0];
                    r_dn_rem <= dn_ge ? DUR_W'(dn_t - {1'b0, r_item.dur}) : dn_t[DUR_W-1:0];
                    r_up_q   <= {r_up_q[DIVD_W-2:0], up_ge};
                    r_dn_q   <= {r_dn_q[DIVD_W-2:0], dn_ge};
                    r_step   <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIVD_W - 1)) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (at_end) begin
                        r_state <= S_EMIT;
                        if (tbl_full) begin
                            r_res_status <= ST_FULL;
                        end else begin
                            r_res_status <= ST_CREATED;
                            r_res        <= new_slot;
                            r_res_idx    <= r_fill[IDX_W-1:0];
                            r_fill       <= r_fill + 1'b1;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (hit) begin
                        r_res_status <= ST_UPDATED;
                        r_res        <= upd_slot;
                        r_res_idx    <= r_idx[IDX_W-1:0];
                        r_state      <= S_EMIT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_out_status <= r_res_status;
                        r_out        <= r_res;
                        r_out_idx    <= r_res_idx;
                        r_out_used   <= r_fill;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty          = !r_out_vld;
    assign o_status         = r_out_status;
    assign o_entry_index    = r_out_idx;
    assign o_conn_count     = r_out.conns;
    assign o_up_rate_sum    = r_out.up;
    assign o_down_rate_sum  = r_out.dn;
    assign o_total_bits_sum = r_out.tot;
    assign o_entries_used   = r_out_used;

    `FSAT_ASSERT(a_fill_bound, r_fill <= CNT_W'(TABLE_DEPTH), "fill count past table depth")
    `FSAT_ASSERT_IMP(a_div_dur, r_state == S_DIV, r_item.dur != '0, "divide by zero duration")
    `FSAT_ASSERT_IMP(a_scan_bound, r_state == S_RD || r_state == S_CMP, r_idx <= r_fill, "search ran past filled slots")
    `FSAT_ASSERT_IMP(a_miss_zero, r_out_vld && r_out_status != ST_UPDATED && r_out_status != ST_CREATED, r_out.conns == '0 && r_out_idx == '0, "non-update result carries slot data")
endmodule

// ===== hw/rtl/flow_stats_aggregation_table.sv =====
// top level of the flow statistics aggregation table
//
// channel   direction  handshake         transfer when
// record    in         push / full       push && !full
// result    out        empty / pop       pop && !empty
// config    in         i_cfg_we          i_cfg_we (index 0 filter on, 1 filter app id)
//
// a record passes the front register and the queue, then in the back: a load state,
// a divide pass when duration is nonzero, a read and a compare state for each slot
// compared (a hit stops at its slot), one more read state on a miss to reach the end
// of the occupied slots, and a result state
// slots are never freed, so occupied slots are 0..fill-1 and no clearing pass is run
// reset clears fill count, filter registers and all handshake state
// a two-entry queue lets the front keep taking records while the back works
// or waits on a full result register
module flow_stats_aggregation_table import fsat_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata,
    // record channel
    input  logic               push,
    output logic               full,
    input  logic [31:0]        i_app_id,
    input  logic [31:0]        i_src_ip,
    input  logic [31:0]        i_dst_ip,
    input  logic [BYTES_W-1:0] i_up_octets,
    input  logic [BYTES_W-1:0] i_dn_octets,
    input  logic [DUR_W-1:0]   i_duration,
    input  logic [1:0]         i_agg_class,
    // result channel
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_status,
    output logic [IDX_W-1:0]   o_entry_index,
    output logic [31:0]        o_conn_count,
    output logic [SUM_W-1:0]   o_up_rate_sum,
    output logic [SUM_W-1:0]   o_down_rate_sum,
    output logic [SUM_W-1:0]   o_total_bits_sum,
    output logic [CNT_W-1:0]   o_entries_used
);
    logic    q_push;
    t_item   q_in;
    t_item   q_out;
    logic    q_pop;
    t_q_stat q_stat;

    // classify and register each record
    fsat_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (push),
        .o_full       (full),
        .i_app_id     (i_app_id),
        .i_src_ip     (i_src_ip),
        .i_dst_ip     (i_dst_ip),
        .i_up_octets  (i_up_octets),
        .i_dn_octets  (i_dn_octets),
        .i_duration   (i_duration),
        .i_agg_class  (i_agg_class),
        .o_q_push     (q_push),
        .o_q_item     (q_in),
        .i_q_stat     (q_stat)
    );

    // decouples front from back
    fsat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_stat  (q_stat)
    );

    // divide, search, update, present result
    fsat_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_item         (q_out),
        .i_q_stat         (q_stat),
        .o_q_pop          (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_status         (o_status),
        .o_entry_index    (o_entry_index),
        .o_conn_count     (o_conn_count),
        .o_up_rate_sum    (o_up_rate_sum),
        .o_down_rate_sum  (o_down_rate_sum),
        .o_total_bits_sum (o_total_bits_sum),
        .o_entries_used   (o_entries_used)
    );
endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the flow statistics aggregation table
`timescale 1ns / 100ps

module testbench;
    import fsat_pkg::*;

    localparam logic [1:0] CLS_BAD   = 2'd3;
    localparam int         SETTLE    = 2300;      // settling wait, above the worst record time with a full table
    localparam longint     MAX_CYC   = 20000000;
    localparam int         HOLD_CYC  = 3000;
    localparam int         POOL_N    = 16;

    typedef struct {
        logic [31:0]        app;
        logic [31:0]        sip;
        logic [31:0]        dip;
        logic [BYTES_W-1:0] upb;
        logic [BYTES_W-1:0] dnb;
        logic [DUR_W-1:0]   dur;
        logic [1:0]         cls;
    } t_flow_rec;

    typedef struct {
        t_status           status;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       conns;
        logic [SUM_W-1:0]  up;
        logic [SUM_W-1:0]  dn;
        logic [SUM_W-1:0]  tot;
        logic [CNT_W-1:0]  used;
    } t_agg_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_addr = 1'b0;
    logic [31:0]        i_cfg_wdata = '0;
    logic               push = 1'b0;
    logic               full;
    logic [31:0]        i_app_id = '0;
    logic [31:0]        i_src_ip = '0;
    logic [31:0]        i_dst_ip = '0;
    logic [BYTES_W-1:0] i_up_octets = '0;
    logic [BYTES_W-1:0] i_dn_octets = '0;
    logic [DUR_W-1:0]   i_duration = '0;
    logic [1:0]         i_agg_class = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [2:0]         o_status;
    logic [IDX_W-1:0]   o_entry_index;
    logic [31:0]        o_conn_count;
    logic [SUM_W-1:0]   o_up_rate_sum;
    logic [SUM_W-1:0]   o_down_rate_sum;
    logic [SUM_W-1:0]   o_total_bits_sum;
    logic [CNT_W-1:0]   o_entries_used;

    flow_stats_aggregation_table u_dut (.*);

    always #10 i_clk = ~i_clk;

    // shadow copy of the aggregation table
    logic               tbl_valid [TABLE_DEPTH];
    logic [1:0]         tbl_cls   [TABLE_DEPTH];
    logic [31:0]        tbl_key   [TABLE_DEPTH];
    logic [31:0]        tbl_conns [TABLE_DEPTH];
    logic [SUM_W-1:0]   tbl_up    [TABLE_DEPTH];
    logic [SUM_W-1:0]   tbl_dn    [TABLE_DEPTH];
    logic [SUM_W-1:0]   tbl_tot   [TABLE_DEPTH];
    int                 tbl_fill = 0;
    logic               flt_en = 1'b0;
    logic [31:0]        flt_id = '0;

    t_flow_rec   pending_recs[$];
    t_agg_result expected_results[$];
    t_flow_rec   cur_rec;
    logic [31:0] app_pool [POOL_N];
    logic [31:0] ip_pool  [POOL_N];

    int     n_status [5];
    int     n_errors = 0;
    int     n_results = 0;
    longint cycle_cnt = 0;
    int     push_gap = 0;
    int     pop_gap = 0;
    int     hold_cnt = 0;
    bit     hold_req = 0;
    bit     no_idle = 0;
    bit     accepted = 0;

    function automatic logic [SUM_W-1:0] add_clip(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] bit_rate(logic [BYTES_W-1:0] nbytes,
                                                  logic [DUR_W-1:0] dur);
        logic [SUM_W-1:0] bits;
        bits = {24'd0, nbytes} << 3;
        return (dur == 0) ? '0 : bits / {32'd0, dur};
    endfunction

    // folds one record into the shadow table and returns the result it should produce
    function t_agg_result aggregate_flow(t_flow_rec r);
        t_agg_result      res;
        logic [31:0]      key;
        logic [SUM_W-1:0] ur, dr, tb;
        int               hit, free_slot;
        res = '{status: ST_FILTERED, idx: '0, conns: '0, up: '0, dn: '0, tot: '0,
                used: '0};
        hit = -1;
        free_slot = -1;
        key = (r.cls == CLS_APP) ? r.app : (r.cls == CLS_SRC) ? r.sip : r.dip;
        if (flt_en && r.app != flt_id) begin
            res.status = ST_FILTERED;
        end else if (r.cls == CLS_BAD) begin
            res.status = ST_BADCLASS;
        end else begin
            ur = bit_rate(r.upb, r.dur);
            dr = bit_rate(r.dnb, r.dur);
            tb = ({24'd0, r.upb} << 3) + ({24'd0, r.dnb} << 3);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (tbl_valid[i]) begin
                    if (hit < 0 && tbl_cls[i] == r.cls && tbl_key[i] == key) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                if (tbl_conns[hit] != '1) tbl_conns[hit]++;
                tbl_up[hit]  = add_clip(tbl_up[hit], ur);
                tbl_dn[hit]  = add_clip(tbl_dn[hit], dr);
                tbl_tot[hit] = add_clip(tbl_tot[hit], tb);
                res.status = ST_UPDATED;
            end else if (free_slot >= 0) begin
                hit = free_slot;
                tbl_valid[hit] = 1'b1;
                tbl_cls[hit]   = r.cls;
                tbl_key[hit]   = key;
                tbl_conns[hit] = 32'd1;
                tbl_up[hit]    = ur;
                tbl_dn[hit]    = dr;
                tbl_tot[hit]   = tb;
                tbl_fill++;
                res.status = ST_CREATED;
            end else begin
                res.status = ST_FULL;
            end
            if (res.status inside {ST_UPDATED, ST_CREATED}) begin
                res.idx   = hit[IDX_W-1:0];
                res.conns = tbl_conns[hit];
                res.up    = tbl_up[hit];
                res.dn    = tbl_dn[hit];
                res.tot   = tbl_tot[hit];
            end
        end
        res.used = tbl_fill[CNT_W-1:0];
        n_status[res.status]++;
        return res;
    endfunction

    // mostly short gaps, a few long ones, none at all while no_idle is set
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [BYTES_W-1:0] rand_bytes();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return w[BYTES_W-1:0];
            1: return BYTES_W'(w[15:0]);
            2: return '1;
            default: return w[BYTES_W-1:0] >> $urandom_range(0, 39);
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] rand_dur();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom;
            2: return 32'd1;
            default: return $urandom_range(1, 100000);
        endcase
    endfunction

    // random record, keys mostly drawn from small pools so that hits dominate
    function automatic t_flow_rec rand_rec();
        t_flow_rec r;
        r.app = ($urandom_range(0, 49) == 0) ? $urandom : app_pool[$urandom_range(0, POOL_N-1)];
        r.sip = ($urandom_range(0, 49) == 0) ? $urandom : ip_pool[$urandom_range(0, POOL_N-1)];
        r.dip = ($urandom_range(0, 49) == 0) ? $urandom : ip_pool[$urandom_range(0, POOL_N-1)];
        r.upb = rand_bytes();
        r.dnb = rand_bytes();
        r.dur = rand_dur();
        r.cls = ($urandom_range(0, 9) == 0) ? CLS_BAD : 2'($urandom_range(0, 2));
        return r;
    endfunction

    function automatic t_flow_rec mk_rec(logic [31:0] app, logic [31:0] sip, logic [31:0] dip,
                                         logic [BYTES_W-1:0] upb, logic [BYTES_W-1:0] dnb,
                                         logic [DUR_W-1:0] dur, logic [1:0] cls);
        t_flow_rec r;
        r = '{app: app, sip: sip, dip: dip, upb: upb, dnb: dnb, dur: dur, cls: cls};
        return r;
    endfunction

    task automatic write_reg(logic addr, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (addr == CFG_FILTER_EN) flt_en = data[0];
        else flt_id = data;
    endtask

    // block is idle once every queued record went in and every result came out
    task automatic drain();
        while (pending_recs.size() != 0 || push || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void chk(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // record driver: a new record or a gap is chosen at the falling edge after a transfer or while not pushing
    always @(negedge i_clk) begin
        if (i_rst_n && (accepted || !push)) begin
            accepted = 0;
            if (push_gap > 0) begin
                push_gap--;
                push <= 1'b0;
            end else if (pending_recs.size() != 0) begin
                cur_rec = pending_recs.pop_front();
                i_app_id     <= cur_rec.app;
                i_src_ip     <= cur_rec.sip;
                i_dst_ip     <= cur_rec.dip;
                i_up_octets  <= cur_rec.upb;
                i_dn_octets  <= cur_rec.dnb;
                i_duration   <= cur_rec.dur;
                i_agg_class  <= cur_rec.cls;
                push         <= 1'b1;
                push_gap = pick_gap(no_idle);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // record transfer: predict at the edge that takes it
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            expected_results.push_back(aggregate_flow(cur_rec));
            accepted = 1;
        end
    end

    // result consumer: random pops, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = HOLD_CYC;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
        end else if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            pop_gap = pick_gap(no_idle);
        end
    end

    // result transfer: compare against the oldest prediction
    always @(posedge i_clk) begin
        t_agg_result e;
        if (i_rst_n && pop && !empty) begin
            n_results++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d",
                         $time, o_status);
                n_errors++;
            end else begin
                e = expected_results.pop_front();
                chk("status", 64'(e.status), 64'(o_status));
                chk("entry_index", 64'(e.idx), 64'(o_entry_index));
                chk("conn_count", 64'(e.conns), 64'(o_conn_count));
                chk("up_rate_sum", e.up, o_up_rate_sum);
                chk("down_rate_sum", e.dn, o_down_rate_sum);
                chk("total_bits_sum", e.tot, o_total_bits_sum);
                chk("entries_used", 64'(e.used), 64'(o_entries_used));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYC) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_flow_rec r;
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < 5; i++) n_status[i] = 0;
        for (int i = 0; i < POOL_N; i++) begin
            app_pool[i] = $urandom;
            ip_pool[i]  = $urandom;
        end
        app_pool[0] = '0;
        app_pool[1] = '1;
        ip_pool[0]  = '0;
        ip_pool[1]  = '1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every class, zero duration, updates
        write_reg(CFG_FILTER_EN, 32'd0);
        write_reg(CFG_FILTER_ID, 32'd0);
        pending_recs.push_back(mk_rec('0, '0, '0, '0, '0, '0, CLS_APP));
        pending_recs.push_back(mk_rec('0, '1, '1, '1, '1, '0, CLS_APP));
        pending_recs.push_back(mk_rec('1, '1, '1, '1, '1, 32'd1, CLS_APP));
        pending_recs.push_back(mk_rec('1, '0, '0, '1, '1, 32'd1, CLS_APP));
        pending_recs.push_back(mk_rec(32'h1234, '1, '0, 40'd1000, 40'd7, 32'd3, CLS_SRC));
        pending_recs.push_back(mk_rec(32'h5678, '1, '1, '1, '0, '1, CLS_SRC));
        pending_recs.push_back(mk_rec(32'h1234, '0, '1, 40'd5, 40'd9, 32'd0, CLS_DST));
        pending_recs.push_back(mk_rec(32'h1, '1, '1, 40'h55_5555_5555, 40'haa_aaaa_aaaa,
                                      32'h5555_5555, CLS_DST));
        pending_recs.push_back(mk_rec('1, '1, '1, '1, '1, '1, CLS_BAD));
        pending_recs.push_back(mk_rec('0, '0, '0, '0, '0, '0, CLS_BAD));
        pending_recs.push_back(mk_rec(32'h1234, '0, '0, 40'd1, 40'd1, 32'd16, CLS_APP));
        pending_recs.push_back(mk_rec(32'hdead, '1, '0, 40'd999, 40'd1, 32'hffff, CLS_SRC));
        drain();

        // filter on, matching id all ones: mismatches dropped before the class check
        write_reg(CFG_FILTER_EN, 32'd1);
        write_reg(CFG_FILTER_ID, '1);
        pending_recs.push_back(mk_rec('1, 32'h10, 32'h20, 40'd80, 40'd80, 32'd8, CLS_SRC));
        pending_recs.push_back(mk_rec('0, 32'h10, 32'h20, 40'd80, 40'd80, 32'd8, CLS_SRC));
        pending_recs.push_back(mk_rec(32'hfffffffe, '0, '0, '1, '1, '1, CLS_BAD));
        pending_recs.push_back(mk_rec('1, '0, '0, '1, '1, '1, CLS_BAD));
        pending_recs.push_back(mk_rec('1, 32'h10, 32'h20, '1, '1, 32'd2, CLS_SRC));
        drain();
        write_reg(CFG_FILTER_ID, '0);
        pending_recs.push_back(mk_rec('0, '1, '0, 40'd12, 40'd34, 32'd5, CLS_DST));
        pending_recs.push_back(mk_rec(32'h8000_0000, '1, '0, 40'd12, 40'd34, 32'd5, CLS_DST));
        drain();

        // random with filter off; the receiver stalls long so the input backs up
        write_reg(CFG_FILTER_EN, 32'd0);
        hold_req = 1;
        for (int i = 0; i < 300; i++) pending_recs.push_back(rand_rec());
        drain();

        // random with filter on a pool id, then a stretch with no idling
        write_reg(CFG_FILTER_EN, 32'd1);
        write_reg(CFG_FILTER_ID, app_pool[$urandom_range(0, POOL_N-1)]);
        for (int i = 0; i < 130; i++) pending_recs.push_back(rand_rec());
        drain();
        write_reg(CFG_FILTER_EN, 32'd0);
        no_idle = 1;
        for (int i = 0; i < 160; i++) pending_recs.push_back(rand_rec());
        drain();

        // fill every slot with cheap zero-duration creates, then probe the full table
        for (int i = 0; i < TABLE_DEPTH + 4; i++) begin
            r = mk_rec($urandom, $urandom, 32'h5a00_0000 + i, 40'(i), 40'd1, '0, CLS_DST);
            pending_recs.push_back(r);
        end
        drain();
        no_idle = 0;
        pending_recs.push_back(mk_rec('1, '1, 32'h5a00_0003, '1, '1, 32'd1, CLS_DST));
        pending_recs.push_back(mk_rec('1, '1, 32'h0bad_0000, '1, '1, 32'd1, CLS_SRC));
        pending_recs.push_back(mk_rec('1, '1, '1, '1, '1, 32'd1, CLS_BAD));
        for (int i = 0; i < 10; i++) pending_recs.push_back(rand_rec());
        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("results checked: %0d (updated %0d, created %0d, filtered %0d, full %0d,",
                 n_results, n_status[ST_UPDATED], n_status[ST_CREATED],
                 n_status[ST_FILTERED], n_status[ST_FULL]);
        $display("  bad class %0d), table ended with %0d of %0d slots in use",
                 n_status[ST_BADCLASS], tbl_fill, TABLE_DEPTH);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
